### rtl/qsd_pkg.sv
package qsd_pkg;

  localparam int DATA_W        = 32;
  localparam int GAIN_W        = 31;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int ACC_W         = PROD_W + 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int NUM_STAGES    = 6;

  localparam logic [GAIN_W-1:0] FORCE_GAIN_RST  = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] MOMENT_GAIN_RST = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] GRAVITY_RST     = GAIN_W'(642253);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORCE_GAIN  = 2'd0,
    CFG_MOMENT_GAIN = 2'd1,
    CFG_GRAVITY     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] force_gain;
    logic [GAIN_W-1:0] moment_gain;
    logic [GAIN_W-1:0] gravity;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quat_w;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    logic signed [DATA_W-1:0] rate_roll;
    logic signed [DATA_W-1:0] rate_pitch;
    logic signed [DATA_W-1:0] rate_yaw;
    logic signed [DATA_W-1:0] motor_front;
    logic signed [DATA_W-1:0] motor_right;
    logic signed [DATA_W-1:0] motor_back;
    logic signed [DATA_W-1:0] motor_left;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quat_rate_w;
    logic signed [DATA_W-1:0] quat_rate_x;
    logic signed [DATA_W-1:0] quat_rate_y;
    logic signed [DATA_W-1:0] quat_rate_z;
    logic signed [DATA_W-1:0] accel_x;
    logic signed [DATA_W-1:0] accel_y;
    logic signed [DATA_W-1:0] accel_z;
    logic signed [DATA_W-1:0] ang_accel_roll;
    logic signed [DATA_W-1:0] ang_accel_pitch;
    logic signed [DATA_W-1:0] ang_accel_yaw;
  } out_item_t;

  // floor shift by the fraction width, then clamp to the signed data range
  function automatic logic signed [DATA_W-1:0] sat_floor(
    input logic signed [ACC_W-1:0] v,
    input int unsigned             frac
  );
    logic signed [ACC_W-1:0] s;
    logic                    ovf;
    s   = v >>> frac;
    ovf = (s[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){s[ACC_W-1]}});
    if (!ovf) begin
      return s[DATA_W-1:0];
    end else if (s[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/qsd_core.sv
module qsd_core import qsd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output logic      valid_o,
  output out_item_t item_o
);

  logic [NUM_STAGES-1:0] valid_q;

  // stage 1: raw products
  logic signed [PROD_W-1:0] qr1_d [12];
  logic signed [PROD_W-1:0] qr1_q [12];
  logic signed [PROD_W-1:0] msq1_d [4];
  logic signed [PROD_W-1:0] msq1_q [4];
  logic signed [PROD_W-1:0] qq1_d [8];
  logic signed [PROD_W-1:0] qq1_q [8];
  logic signed [PROD_W-1:0] rr1_d [2];
  logic signed [PROD_W-1:0] rr1_q [2];

  // stage 2: sums, rounded
  logic signed [DATA_W-1:0] qrate2_d [4];
  logic signed [DATA_W-1:0] qrate2_q [4];
  logic signed [DATA_W-1:0] thrust2_d, thrust2_q;
  logic signed [DATA_W-1:0] tq2_d [3];
  logic signed [DATA_W-1:0] tq2_q [3];
  logic signed [DATA_W-1:0] diff2_d [3];
  logic signed [DATA_W-1:0] diff2_q [3];
  logic signed [PROD_W-1:0] rr2_q [2];

  // stage 3: gain products
  logic signed [PROD_W-1:0] kprod3_d, kprod3_q;
  logic signed [PROD_W-1:0] mgp3_d [3];
  logic signed [PROD_W-1:0] mgp3_q [3];
  logic signed [DATA_W-1:0] qrate3_q [4];
  logic signed [DATA_W-1:0] tq3_q [3];
  logic signed [PROD_W-1:0] rr3_q [2];

  // stage 4: thrust gain and angular terms
  logic signed [DATA_W-1:0] k4_d, k4_q;
  logic signed [DATA_W-1:0] ang4_d [3];
  logic signed [DATA_W-1:0] ang4_q [3];
  logic signed [DATA_W-1:0] qrate4_q [4];
  logic signed [DATA_W-1:0] tq4_q [3];

  // stage 5: linear products
  logic signed [PROD_W-1:0] lin5_d [3];
  logic signed [PROD_W-1:0] lin5_q [3];
  logic signed [DATA_W-1:0] qrate5_q [4];
  logic signed [DATA_W-1:0] ang5_q [3];

  // stage 6: result
  logic signed [ACC_W-1:0]  grav_term;
  out_item_t                out6_d, out6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NUM_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[NUM_STAGES-1];

  always_comb begin
    qr1_d[0]  = item_i.rate_roll  * item_i.quat_x;
    qr1_d[1]  = item_i.rate_pitch * item_i.quat_y;
    qr1_d[2]  = item_i.rate_yaw   * item_i.quat_z;
    qr1_d[3]  = item_i.rate_roll  * item_i.quat_w;
    qr1_d[4]  = item_i.rate_pitch * item_i.quat_z;
    qr1_d[5]  = item_i.rate_yaw   * item_i.quat_y;
    qr1_d[6]  = item_i.rate_roll  * item_i.quat_z;
    qr1_d[7]  = item_i.rate_pitch * item_i.quat_w;
    qr1_d[8]  = item_i.rate_yaw   * item_i.quat_x;
    qr1_d[9]  = item_i.rate_roll  * item_i.quat_y;
    qr1_d[10] = item_i.rate_pitch * item_i.quat_x;
    qr1_d[11] = item_i.rate_yaw   * item_i.quat_w;
    msq1_d[0] = item_i.motor_front * item_i.motor_front;
    msq1_d[1] = item_i.motor_right * item_i.motor_right;
    msq1_d[2] = item_i.motor_back  * item_i.motor_back;
    msq1_d[3] = item_i.motor_left  * item_i.motor_left;
    qq1_d[0]  = item_i.quat_w * item_i.quat_z;
    qq1_d[1]  = item_i.quat_x * item_i.quat_y;
    qq1_d[2]  = item_i.quat_w * item_i.quat_w;
    qq1_d[3]  = item_i.quat_x * item_i.quat_x;
    qq1_d[4]  = item_i.quat_y * item_i.quat_y;
    qq1_d[5]  = item_i.quat_z * item_i.quat_z;
    qq1_d[6]  = item_i.quat_w * item_i.quat_x;
    qq1_d[7]  = item_i.quat_y * item_i.quat_z;
    rr1_d[0]  = item_i.rate_pitch * item_i.rate_yaw;
    rr1_d[1]  = item_i.rate_roll  * item_i.rate_yaw;
  end

  always_comb begin
    qrate2_d[0] = sat_floor(-ACC_W'(qr1_q[0]) - ACC_W'(qr1_q[1]) - ACC_W'(qr1_q[2]), FRAC_BITS);
    qrate2_d[1] = sat_floor(ACC_W'(qr1_q[3]) + ACC_W'(qr1_q[4]) - ACC_W'(qr1_q[5]), FRAC_BITS);
    qrate2_d[2] = sat_floor(-ACC_W'(qr1_q[6]) + ACC_W'(qr1_q[7]) + ACC_W'(qr1_q[8]), FRAC_BITS);
    qrate2_d[3] = sat_floor(ACC_W'(qr1_q[9]) - ACC_W'(qr1_q[10]) + ACC_W'(qr1_q[11]), FRAC_BITS);
    thrust2_d   = sat_floor(ACC_W'(msq1_q[0]) + ACC_W'(msq1_q[1]) + ACC_W'(msq1_q[2])
                            + ACC_W'(msq1_q[3]), FRAC_BITS);
    tq2_d[0]    = sat_floor((ACC_W'(qq1_q[0]) + ACC_W'(qq1_q[1])) <<< 1, FRAC_BITS);
    tq2_d[1]    = sat_floor(ACC_W'(qq1_q[2]) - ACC_W'(qq1_q[3]) - ACC_W'(qq1_q[4])
                            - ACC_W'(qq1_q[5]), FRAC_BITS);
    tq2_d[2]    = sat_floor((ACC_W'(qq1_q[6]) + ACC_W'(qq1_q[7])) <<< 1, FRAC_BITS);
    // roll: right minus left, pitch: back minus front, yaw: front+back-left-right
    diff2_d[0]  = sat_floor(ACC_W'(msq1_q[1]) - ACC_W'(msq1_q[3]), FRAC_BITS);
    diff2_d[1]  = sat_floor(ACC_W'(msq1_q[2]) - ACC_W'(msq1_q[0]), FRAC_BITS);
    diff2_d[2]  = sat_floor(ACC_W'(msq1_q[0]) + ACC_W'(msq1_q[2]) - ACC_W'(msq1_q[3])
                            - ACC_W'(msq1_q[1]), FRAC_BITS);
  end

  always_comb begin
    kprod3_d = $signed({1'b0, cfg_i.force_gain}) * thrust2_q;
    for (int i = 0; i < 3; i++) begin
      mgp3_d[i] = $signed({1'b0, cfg_i.moment_gain}) * diff2_q[i];
    end
  end

  always_comb begin
    k4_d      = sat_floor(ACC_W'(kprod3_q), FRAC_BITS);
    ang4_d[0] = sat_floor(-ACC_W'(rr3_q[0]) + (ACC_W'(mgp3_q[0]) <<< 1), FRAC_BITS);
    ang4_d[1] = sat_floor(ACC_W'(rr3_q[1]) + (ACC_W'(mgp3_q[1]) <<< 1), FRAC_BITS);
    ang4_d[2] = sat_floor(ACC_W'(mgp3_q[2]), FRAC_BITS);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lin5_d[i] = tq4_q[i] * k4_q;
    end
  end

  always_comb begin
    grav_term              = $signed(ACC_W'({1'b0, cfg_i.gravity})) <<< FRAC_BITS;
    out6_d.quat_rate_w     = qrate5_q[0];
    out6_d.quat_rate_x     = qrate5_q[1];
    out6_d.quat_rate_y     = qrate5_q[2];
    out6_d.quat_rate_z     = qrate5_q[3];
    out6_d.accel_x         = sat_floor(ACC_W'(lin5_q[0]), FRAC_BITS);
    out6_d.accel_y         = sat_floor(ACC_W'(lin5_q[1]), FRAC_BITS);
    out6_d.accel_z         = sat_floor(ACC_W'(lin5_q[2]) - grav_term, FRAC_BITS);
    out6_d.ang_accel_roll  = ang5_q[0];
    out6_d.ang_accel_pitch = ang5_q[1];
    out6_d.ang_accel_yaw   = ang5_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qr1_q     <= qr1_d;
      msq1_q    <= msq1_d;
      qq1_q     <= qq1_d;
      rr1_q     <= rr1_d;
      qrate2_q  <= qrate2_d;
      thrust2_q <= thrust2_d;
      tq2_q     <= tq2_d;
      diff2_q   <= diff2_d;
      rr2_q     <= rr1_q;
      kprod3_q  <= kprod3_d;
      mgp3_q    <= mgp3_d;
      qrate3_q  <= qrate2_q;
      tq3_q     <= tq2_q;
      rr3_q     <= rr2_q;
      k4_q      <= k4_d;
      ang4_q    <= ang4_d;
      qrate4_q  <= qrate3_q;
      tq4_q     <= tq3_q;
      lin5_q    <= lin5_d;
      qrate5_q  <= qrate4_q;
      ang5_q    <= ang4_q;
      out6_q    <= out6_d;
    end
  end

  assign item_o = out6_q;

`ifndef SYNTHESIS
  // a stall freezes every stage
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> valid_q == $past(valid_q) && $stable(thrust2_q) && $stable(k4_q))
    else $error("pipeline moved during stall");

  // sum of squared speeds never comes out negative
  a_thrust_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> !thrust2_q[DATA_W-1])
    else $error("negative total thrust");

  // unsigned gain times non-negative thrust stays non-negative
  a_k_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] |-> !k4_q[DATA_W-1])
    else $error("negative thrust gain product");
`endif

endmodule

### rtl/quadrotor_state_derivative_top.sv
// throughput: one beat per cycle; the six-stage multiplier pipeline advances as a whole
// and holds only while its last stage has a result that is not taken
// reset (rst_ni low, asynchronous): pipeline emptied, gains and gravity back to defaults
module quadrotor_state_derivative_top import qsd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [GAIN_W-1:0]           cfg_data_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [DATA_W-1:0]    quat_w_i,
  input  logic signed [DATA_W-1:0]    quat_x_i,
  input  logic signed [DATA_W-1:0]    quat_y_i,
  input  logic signed [DATA_W-1:0]    quat_z_i,
  input  logic signed [DATA_W-1:0]    rate_roll_i,
  input  logic signed [DATA_W-1:0]    rate_pitch_i,
  input  logic signed [DATA_W-1:0]    rate_yaw_i,
  input  logic signed [DATA_W-1:0]    motor_front_i,
  input  logic signed [DATA_W-1:0]    motor_right_i,
  input  logic signed [DATA_W-1:0]    motor_back_i,
  input  logic signed [DATA_W-1:0]    motor_left_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DATA_W-1:0]    quat_rate_w_o,
  output logic signed [DATA_W-1:0]    quat_rate_x_o,
  output logic signed [DATA_W-1:0]    quat_rate_y_o,
  output logic signed [DATA_W-1:0]    quat_rate_z_o,
  output logic signed [DATA_W-1:0]    accel_x_o,
  output logic signed [DATA_W-1:0]    accel_y_o,
  output logic signed [DATA_W-1:0]    accel_z_o,
  output logic signed [DATA_W-1:0]    ang_accel_roll_o,
  output logic signed [DATA_W-1:0]    ang_accel_pitch_o,
  output logic signed [DATA_W-1:0]    ang_accel_yaw_o
);

  cfg_t      cfg_q;
  in_item_t  in_item;
  out_item_t out_item;
  logic      pipe_en;
  logic      pipe_valid;

  // config writes are always taken; an index past the register list is dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_gain  <= FORCE_GAIN_RST;
      cfg_q.moment_gain <= MOMENT_GAIN_RST;
      cfg_q.gravity     <= GRAVITY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FORCE_GAIN:  cfg_q.force_gain  <= cfg_data_i;
        CFG_MOMENT_GAIN: cfg_q.moment_gain <= cfg_data_i;
        CFG_GRAVITY:     cfg_q.gravity     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // the whole pipeline moves unless a finished beat sits unaccepted at the end;
  // the last stage register doubles as the output register
  assign pipe_en    = !pipe_valid || out_ready_i;
  assign in_ready_o = pipe_en;

  assign in_item.quat_w      = quat_w_i;
  assign in_item.quat_x      = quat_x_i;
  assign in_item.quat_y      = quat_y_i;
  assign in_item.quat_z      = quat_z_i;
  assign in_item.rate_roll   = rate_roll_i;
  assign in_item.rate_pitch  = rate_pitch_i;
  assign in_item.rate_yaw    = rate_yaw_i;
  assign in_item.motor_front = motor_front_i;
  assign in_item.motor_right = motor_right_i;
  assign in_item.motor_back  = motor_back_i;
  assign in_item.motor_left  = motor_left_i;

  // products, sums, gain products, gain rounding, linear products, final rounding
  qsd_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_i),
    .item_i  (in_item),
    .cfg_i   (cfg_q),
    .valid_o (pipe_valid),
    .item_o  (out_item)
  );

  assign out_valid_o       = pipe_valid;
  assign quat_rate_w_o     = out_item.quat_rate_w;
  assign quat_rate_x_o     = out_item.quat_rate_x;
  assign quat_rate_y_o     = out_item.quat_rate_y;
  assign quat_rate_z_o     = out_item.quat_rate_z;
  assign accel_x_o         = out_item.accel_x;
  assign accel_y_o         = out_item.accel_y;
  assign accel_z_o         = out_item.accel_z;
  assign ang_accel_roll_o  = out_item.ang_accel_roll;
  assign ang_accel_pitch_o = out_item.ang_accel_pitch;
  assign ang_accel_yaw_o   = out_item.ang_accel_yaw;

endmodule
